FILE: rtl/core/mwg_pkg.sv
// ----------------------------------------------------------------------------
// mwg_pkg: shared definitions for the multi-waveform tone generator
// Widths, reset values, register and waveform codes, and the quarter-wave
// sine function that fills the lookup table at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package mwg_pkg;

	// Default values of the top level parameters.
	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int AMPLITUDE_DEF       = 32767;

	// Fixed field widths.
	localparam int AMP_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int STEP_W     = 32;
	localparam int COUNT_W    = 32;

	// Register reset values.
	localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 32'd50955259;
	localparam logic [COUNT_W-1:0] RUN_LENGTH_RST = 32'd220500;

	// pi/2 in Q30.
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SAWTOOTH = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SQUARE   = 2'd3
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_WAVEFORM   = 2'd1,
		CFG_RUN_LENGTH = 2'd2
	} cfg_idx_t;

	// Quarter-wave sine magnitude at table position k of 2^addr_bits, scaled by amp.
	// Integer Taylor series in Q30 with the odd terms up to the seventeenth power.
	function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned k,
		input int unsigned addr_bits, input int unsigned amp);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		logic [63:0] v;
		if (64'(k) >= (64'd1 << addr_bits)) begin
			return AMP_W'(amp);
		end
		x    = (64'(k) * PI_HALF_Q30) >> addr_bits;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		acc  = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		acc  = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		acc  = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		acc  = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd272;
		acc  = acc + longint'(term);
		if (acc < 0) begin
			acc = 0;
		end
		v = (64'(amp) * 64'(acc)) >> 30;
		if (v > 64'(amp)) begin
			v = 64'(amp);
		end
		return AMP_W'(v);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/multi_waveform_generator.sv
// ----------------------------------------------------------------------------
// multi_waveform_generator: direct digital synthesis tone source
// Sine, sawtooth, triangle and square samples from a phase accumulator,
// with the last sample of each run flagged and phase and count restarted.
// ----------------------------------------------------------------------------
// A sample is valid at the output once it has passed the stage one, two and
// three registers. Throughput: one tick beat per cycle; the three-stage pipeline
// only stalls where the output is held and every stage behind it is full.
// Reset: phase and sample count clear to zero, registers take their reset
// values and all pipeline stages are empty.
`default_nettype none

module multi_waveform_generator #(
	parameter int PHASE_BITS      = mwg_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = mwg_pkg::TABLE_ADDR_BITS_DEF,
	parameter int AMPLITUDE       = mwg_pkg::AMPLITUDE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration write channel.
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mwg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mwg_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Sample request channel.
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               tick,
	// Sample channel.
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [mwg_pkg::SAMPLE_W-1:0]     sample,
	output logic                                    last
);
	import mwg_pkg::*;

	// Magnitudes of the linear waveforms run from zero to one full cycle, so
	// they need one bit more than the phase. The amplitude product is split
	// into two halves so that each multiplier takes only half the magnitude bits.
	localparam int MAG_W  = PHASE_BITS + 1;
	localparam int LO_W   = (MAG_W + 1) / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int PROD_W = MAG_W + AMP_W;
	localparam int SUM_W  = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
	localparam int TA     = TABLE_ADDR_BITS;

	localparam logic [AMP_W-1:0]        AMP        = AMP_W'(AMPLITUDE);
	localparam logic [MAG_W-1:0]        FULL_CYCLE = MAG_W'(1) << PHASE_BITS;
	localparam logic [PHASE_BITS+1:0]   FULL_W2    = (PHASE_BITS+2)'(1) << PHASE_BITS;
	localparam logic [PHASE_BITS+1:0]   THREE_W2   = (PHASE_BITS+2)'(3) << PHASE_BITS;
	localparam logic [TA:0]             QUARTER_N  = (TA+1)'(1) << TA;

	// ------------------------------------------------------------------------
	// Configuration registers. Writes are taken on every cycle; an index past
	// the register list is dropped.
	// ------------------------------------------------------------------------
	logic [STEP_W-1:0]  phase_step_q;
	wave_t              wave_sel_q;
	logic [COUNT_W-1:0] run_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
			wave_sel_q   <= WAVE_SINE;
			run_length_q <= RUN_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PHASE_STEP: phase_step_q <= cfg_data;
				CFG_WAVEFORM:   wave_sel_q   <= wave_t'(cfg_data[1:0]);
				CFG_RUN_LENGTH: run_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Pipeline flow control. Each stage loads when it is empty or when the
	// stage ahead of it moves on, so bubbles close up and a held output only
	// stops the input once every stage is occupied.
	// ------------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;
	logic take;

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// A beat with tick low is consumed without producing a sample.
	assign take = in_valid && in_ready && tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= take;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Phase accumulator and run counter. The sample uses the phase as it was
	// before the beat; the run ends when the incremented count reaches the
	// run length, and a run length of zero ends every run at once.
	// ------------------------------------------------------------------------
	logic [PHASE_BITS-1:0] phase_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W:0]      count_inc;
	logic [SUM_W-1:0]      phase_sum;
	logic                  run_end;

	assign count_inc = {1'b0, count_q} + (COUNT_W+1)'(1);
	assign run_end   = count_inc >= {1'b0, run_length_q};
	assign phase_sum = SUM_W'(phase_q) + SUM_W'(phase_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (take) begin
			if (run_end) begin
				phase_q <= '0;
				count_q <= '0;
			end else begin
				phase_q <= phase_sum[PHASE_BITS-1:0];
				count_q <= count_inc[COUNT_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage one: magnitude and sign of the linear waveforms, and the table
	// address for the sine. The odd quadrants mirror the table index.
	// ------------------------------------------------------------------------
	logic [1:0]            quad;
	logic [TA-1:0]         idx_raw;
	logic [TA:0]           rom_addr;
	logic [MAG_W-1:0]      t2;
	logic [PHASE_BITS+1:0] t4;
	logic [PHASE_BITS+1:0] tri_diff;
	logic [MAG_W-1:0]      mag_d;
	logic                  neg_d;

	assign quad     = phase_q[PHASE_BITS-1 -: 2];
	assign idx_raw  = phase_q[PHASE_BITS-3 -: TA];
	assign rom_addr = quad[0] ? (QUARTER_N - {1'b0, idx_raw}) : {1'b0, idx_raw};
	assign t2       = {phase_q, 1'b0};
	assign t4       = {phase_q, 2'b00};

	always_comb begin
		case (quad)
			2'b00:   tri_diff = FULL_W2 - t4;
			2'b01:   tri_diff = t4 - FULL_W2;
			2'b10:   tri_diff = THREE_W2 - t4;
			default: tri_diff = t4 - THREE_W2;
		endcase
	end

	always_comb begin
		case (wave_sel_q)
			WAVE_SAWTOOTH: begin
				mag_d = quad[1] ? (t2 - FULL_CYCLE) : (FULL_CYCLE - t2);
				neg_d = !quad[1];
			end
			WAVE_TRIANGLE: begin
				mag_d = tri_diff[MAG_W-1:0];
				neg_d = (quad == 2'b00) || (quad == 2'b11);
			end
			WAVE_SQUARE: begin
				// A full cycle scales to exactly the amplitude.
				mag_d = FULL_CYCLE;
				neg_d = quad[1];
			end
			default: begin
				mag_d = '0;
				neg_d = quad[1];
			end
		endcase
	end

	logic [MAG_W-1:0] mag_s1;
	logic             neg_s1;
	logic             sine_s1;
	logic             last_s1;
	logic [AMP_W-1:0] rom_s1;

	mwg_sine_rom #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS),
		.AMPLITUDE      (AMPLITUDE)
	) u_rom (
		.clk (clk),
		.en  (adv_s1),
		.addr(rom_addr),
		.data(rom_s1)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mag_s1  <= mag_d;
			neg_s1  <= neg_d;
			sine_s1 <= (wave_sel_q == WAVE_SINE);
			last_s1 <= run_end;
		end
	end

	// ------------------------------------------------------------------------
	// Stage two: the two partial products of amplitude times magnitude.
	// ------------------------------------------------------------------------
	logic [AMP_W+LO_W-1:0] prod_lo_s2;
	logic [AMP_W+HI_W-1:0] prod_hi_s2;
	logic                  neg_s2;
	logic                  sine_s2;
	logic                  last_s2;
	logic [AMP_W-1:0]      rom_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_lo_s2 <= (AMP_W+LO_W)'(AMP) * (AMP_W+LO_W)'(mag_s1[LO_W-1:0]);
			prod_hi_s2 <= (AMP_W+HI_W)'(AMP) * (AMP_W+HI_W)'(mag_s1[MAG_W-1:LO_W]);
			neg_s2     <= neg_s1;
			sine_s2    <= sine_s1;
			last_s2    <= last_s1;
			rom_s2     <= rom_s1;
		end
	end

	// ------------------------------------------------------------------------
	// Stage three, the output register: join the partial products, drop the
	// truncating phase fraction or take the table sine, and apply the sign.
	// ------------------------------------------------------------------------
	logic [PROD_W-1:0]       prod_full;
	logic [AMP_W-1:0]        scaled;
	logic [AMP_W-1:0]        mag_out;
	logic [SAMPLE_W-1:0]     mag_ext;
	logic signed [SAMPLE_W-1:0] sample_s3;
	logic                    last_s3;

	assign prod_full = (PROD_W'(prod_hi_s2) << LO_W) + PROD_W'(prod_lo_s2);
	assign scaled    = prod_full[PHASE_BITS +: AMP_W];
	assign mag_out   = sine_s2 ? rom_s2 : scaled;
	assign mag_ext   = SAMPLE_W'(mag_out);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			sample_s3 <= neg_s2 ? signed'(-mag_ext) : signed'(mag_ext);
			last_s3   <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign sample    = sample_s3;
	assign last      = last_s3;

endmodule

`default_nettype wire

FILE: rtl/core/mwg_sine_rom.sv
// ----------------------------------------------------------------------------
// mwg_sine_rom: quarter-wave sine lookup
// Holds the sine magnitude for table positions 0 to 2^TABLE_ADDR_BITS
// inclusive, with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_sine_rom #(
	parameter int TABLE_ADDR_BITS = mwg_pkg::TABLE_ADDR_BITS_DEF,
	parameter int AMPLITUDE       = mwg_pkg::AMPLITUDE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [TABLE_ADDR_BITS:0]     addr,
	output logic      [mwg_pkg::AMP_W-1:0]    data
);
	import mwg_pkg::*;

	localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;

	logic [AMP_W-1:0] rom [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		assign rom[k] = quarter_sine(k, TABLE_ADDR_BITS, AMPLITUDE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom[addr];
		end
	end

endmodule

`default_nettype wire
